// ===== rtl/apsp_pkg.sv =====
// shared constants, register codes and helpers for the all-pairs shortest path block
// no dependencies
package apsp_pkg;

   localparam int MAX_NODES_DEF = 16;
   localparam int LEN_BITS_DEF  = 8;
   localparam int DIST_BITS     = 12;
   localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_NODE_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN    = 1'b1;

   localparam logic [4:0] NODE_COUNT_RST = 5'd16;
   localparam logic [7:0] MAX_LEN_RST    = 8'd255;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic host_we;
      logic host_re;
      logic col_re;
      logic col_latch;
      logic inj_en;
   } cell_ctrl_type;

   function automatic logic [DIST_BITS-1:0] sat_add(input logic [DIST_BITS-1:0] a,
                                                     input logic [DIST_BITS-1:0] b);
      logic [DIST_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[DIST_BITS] ? DIST_MAX : s[DIST_BITS-1:0];
   endfunction

endpackage

// ===== rtl/all_pairs_shortest_path.sv =====
// top level: ring of row cells, sequencer and stream port packing
// depends on apsp_pkg, apsp_ctrl, apsp_cell
//
// channel  dir  handshake                 payload
// req      in   req_tvalid / req_tready   tdata row,col,road_length,road_absent; tuser func; tlast last_load
// rsp      out  rsp_tvalid / rsp_tready   tdata node,distance; tuser unreachable; tlast last
// csr      in   csr_we                    csr_index, csr_wdata
//
// the load marked last runs n pivot phases, each long enough for the row stream to pass around the ring
// a query reads and checks each walked node, then reads out and sends each result node
// synchronous reset clears control and sets the csr defaults; matrix contents stay undefined
// req is taken only while idle; a result waiting on rsp_tready stalls the walk, not the ring
module all_pairs_shortest_path
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int LEN_BITS  = LEN_BITS_DEF,
   localparam int NODE_W = $clog2(MAX_NODES),
   localparam int REQ_DW = ((2 * NODE_W + LEN_BITS + 1 + 7) / 8) * 8,
   localparam int RSP_DW = ((NODE_W + DIST_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DW-1:0]     req_tdata,   // row, col, road_length, road_absent
   input  logic                  req_tuser,   // func
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DW-1:0]     rsp_tdata,   // node, distance
   output logic                  rsp_tuser,   // unreachable
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int PRED_W = $clog2(MAX_NODES + 2);
   localparam int ENT_W  = DIST_BITS + PRED_W;

   cell_ctrl_type cell_ctrl;
   logic [NODE_W-1:0] host_sel, addr, k;
   logic [CNT_W-1:0] n;
   logic [ENT_W-1:0] host_wdata;
   logic [NODE_W-1:0] rsp_node;
   logic [DIST_BITS-1:0] rsp_distance;

   logic              ring_v   [MAX_NODES];
   logic [NODE_W-1:0] ring_j   [MAX_NODES];
   logic [ENT_W-1:0]  ring_ent [MAX_NODES];
   logic [ENT_W-1:0]  cell_rdata [MAX_NODES];

   apsp_ctrl #(.MAX_NODES(MAX_NODES), .LEN_BITS(LEN_BITS)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_tvalid),
      .req_ready       (req_tready),
      .req_func        (req_tuser),
      .req_row         (req_tdata[NODE_W-1:0]),
      .req_col         (req_tdata[2*NODE_W-1:NODE_W]),
      .req_len         (req_tdata[2*NODE_W+LEN_BITS-1:2*NODE_W]),
      .req_absent      (req_tdata[2*NODE_W+LEN_BITS]),
      .req_last_load   (req_tlast),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_node        (rsp_node),
      .rsp_distance    (rsp_distance),
      .rsp_unreachable (rsp_tuser),
      .rsp_last        (rsp_tlast),
      .cell_ctrl       (cell_ctrl),
      .host_sel        (host_sel),
      .addr            (addr),
      .k               (k),
      .n               (n),
      .host_wdata      (host_wdata),
      .host_rdata      (cell_rdata[host_sel])
   );

   for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
      localparam int PREV = (i + MAX_NODES - 1) % MAX_NODES;
      apsp_cell #(.MAX_NODES(MAX_NODES), .CELL_ID(i)) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .host_sel   (host_sel),
         .addr       (addr),
         .k          (k),
         .n          (n),
         .host_wdata (host_wdata),
         .in_valid   (ring_v[PREV]),
         .in_j       (ring_j[PREV]),
         .in_ent     (ring_ent[PREV]),
         .out_valid  (ring_v[i]),
         .out_j      (ring_j[i]),
         .out_ent    (ring_ent[i]),
         .rdata      (cell_rdata[i])
      );
   end

   assign rsp_tdata = RSP_DW'({rsp_distance, rsp_node});

endmodule

// ===== rtl/apsp_ram.sv =====
// generic single write, single read RAM with registered read data
// no dependencies
module apsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/apsp_cell.sv =====
// one ring cell: holds one matrix row, relaxes it against the streamed pivot row
// depends on apsp_pkg and apsp_ram
module apsp_cell
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int CELL_ID   = 0,
   localparam int NODE_W = $clog2(MAX_NODES),
   localparam int CNT_W  = $clog2(MAX_NODES + 1),
   localparam int PRED_W = $clog2(MAX_NODES + 2),
   localparam int ENT_W  = DIST_BITS + PRED_W
) (
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic [NODE_W-1:0] host_sel,
   input  logic [NODE_W-1:0] addr,
   input  logic [NODE_W-1:0] k,
   input  logic [CNT_W-1:0]  n,
   input  logic [ENT_W-1:0]  host_wdata,
   input  logic              in_valid,
   input  logic [NODE_W-1:0] in_j,
   input  logic [ENT_W-1:0]  in_ent,
   output logic              out_valid,
   output logic [NODE_W-1:0] out_j,
   output logic [ENT_W-1:0]  out_ent,
   output logic [ENT_W-1:0]  rdata
);

   logic is_k, active, host_hit, relax_rd, upd;
   logic re, we;
   logic [NODE_W-1:0] raddr, waddr;
   logic [ENT_W-1:0] wdata;
   logic [DIST_BITS-1:0] sum;

   logic              stage_v_ff;
   logic [NODE_W-1:0] stage_j_ff;
   logic [ENT_W-1:0]  stage_ent_ff;
   logic [DIST_BITS-1:0] dik_ff;
   logic              inj_v_ff;
   logic [NODE_W-1:0] inj_j_ff;
   logic              out_v_ff, out_v_in;
   logic [NODE_W-1:0] out_j_ff, out_j_in;
   logic [ENT_W-1:0]  out_ent_ff, out_ent_in;

   assign is_k     = (k == NODE_W'(CELL_ID));
   assign active   = !is_k && (CNT_W'(CELL_ID) < n);
   assign host_hit = (host_sel == NODE_W'(CELL_ID));
   assign relax_rd = in_valid && active;

   assign re    = (ctrl.host_re && host_hit) || ctrl.col_re || (ctrl.inj_en && is_k) || relax_rd;
   assign raddr = relax_rd ? in_j : addr;

   assign sum   = sat_add(dik_ff, stage_ent_ff[ENT_W-1:PRED_W]);
   assign upd   = stage_v_ff && (rdata[ENT_W-1:PRED_W] > sum);
   assign we    = (ctrl.host_we && host_hit) || upd;
   assign waddr = upd ? stage_j_ff : addr;
   assign wdata = upd ? {sum, stage_ent_ff[PRED_W-1:0]} : host_wdata;

   apsp_ram #(.WIDTH(ENT_W), .DEPTH(MAX_NODES)) u_row (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   always_comb begin
      if (is_k) begin
         out_v_in   = inj_v_ff;
         out_j_in   = inj_j_ff;
         out_ent_in = rdata;
      end else begin
         out_v_in   = in_valid;
         out_j_in   = in_j;
         out_ent_in = in_ent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
         inj_v_ff   <= 1'b0;
         out_v_ff   <= 1'b0;
      end else begin
         stage_v_ff <= relax_rd;
         inj_v_ff   <= ctrl.inj_en && is_k;
         out_v_ff   <= out_v_in;
      end
      stage_j_ff   <= in_j;
      stage_ent_ff <= in_ent;
      inj_j_ff     <= addr;
      out_j_ff     <= out_j_in;
      out_ent_ff   <= out_ent_in;
      if (ctrl.col_latch) begin
         dik_ff <= rdata[ENT_W-1:PRED_W];
      end
   end

   assign out_valid = out_v_ff;
   assign out_j     = out_j_ff;
   assign out_ent   = out_ent_ff;

`ifndef SYNTH
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !(upd && ctrl.host_we && host_hit))
      else $error("relax update collides with host write");
   a_stage_from_ring: assert property (@(posedge clock) disable iff (reset)
      stage_v_ff |-> $past(in_valid))
      else $error("relax stage without a ring transfer");
   a_latch_ring_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.col_latch |-> !stage_v_ff && !in_valid)
      else $error("pivot column latched while the ring is busy");
`endif

endmodule

// ===== rtl/apsp_ctrl.sv =====
// sequencer: csr registers, load, relaxation phases, path walk and result register
// depends on apsp_pkg and apsp_ram
module apsp_ctrl
   import apsp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int LEN_BITS  = LEN_BITS_DEF,
   localparam int NODE_W = $clog2(MAX_NODES),
   localparam int CNT_W  = $clog2(MAX_NODES + 1),
   localparam int PRED_W = $clog2(MAX_NODES + 2),
   localparam int ENT_W  = DIST_BITS + PRED_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [NODE_W-1:0]     req_row,
   input  logic [NODE_W-1:0]     req_col,
   input  logic [LEN_BITS-1:0]   req_len,
   input  logic                  req_absent,
   input  logic                  req_last_load,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [NODE_W-1:0]     rsp_node,
   output logic [DIST_BITS-1:0]  rsp_distance,
   output logic                  rsp_unreachable,
   output logic                  rsp_last,
   output cell_ctrl_type         cell_ctrl,
   output logic [NODE_W-1:0]     host_sel,
   output logic [NODE_W-1:0]     addr,
   output logic [NODE_W-1:0]     k,
   output logic [CNT_W-1:0]      n,
   output logic [ENT_W-1:0]      host_wdata,
   input  logic [ENT_W-1:0]      host_rdata
);

   localparam int S_W    = $clog2(2 * MAX_NODES + 6);
   localparam int PROD_W = CNT_W + 9;
   localparam logic [PRED_W-1:0] PRED_NONE = PRED_W'(MAX_NODES);
   localparam logic [PRED_W-1:0] PRED_SELF = PRED_W'(MAX_NODES + 1);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_RELAX = 8'b0000_0010,
      S_QRD   = 8'b0000_0100,
      S_QCHK  = 8'b0000_1000,
      S_ORD   = 8'b0001_0000,
      S_OUT   = 8'b0010_0000,
      S_ONE   = 8'b0100_0000,
      S_ERR   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] node_count_ff;
   logic [7:0] max_len_ff;
   logic [NODE_W-1:0] k_ff, k_in;
   logic [S_W-1:0] s_ff, s_in;
   logic [NODE_W-1:0] r_ff, r_in, c_ff, c_in, cur_ff, cur_in;
   logic [NODE_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in;
   logic [DIST_BITS-1:0] d_ff, d_in;
   logic first_ff, first_in;
   logic rsp_v_ff, rsp_v_in;
   logic [NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic [DIST_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic rsp_unr_ff, rsp_unr_in, rsp_last_ff, rsp_last_in;

   logic accept, in_range, slot_free, rsp_load;
   logic [PROD_W-1:0] prod;
   logic [DIST_BITS-1:0] inf, len_d;
   logic [PRED_W-1:0] p;
   logic buf_we, buf_re;
   logic [NODE_W-1:0] buf_waddr, buf_wdata, buf_rdata;

   always_comb begin
      if (node_count_ff < 5'd2) begin
         n = CNT_W'(2);
      end else if (int'(node_count_ff) > MAX_NODES) begin
         n = CNT_W'(MAX_NODES);
      end else begin
         n = CNT_W'(node_count_ff);
      end
   end

   assign prod  = PROD_W'(n) * PROD_W'(max_len_ff);
   assign inf   = (int'(prod) >= int'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(prod + PROD_W'(1));
   assign len_d = (int'(req_len) > int'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(req_len);

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign in_range  = (CNT_W'(req_row) < n) && (CNT_W'(req_col) < n);
   assign slot_free = !rsp_v_ff || rsp_ready;
   assign p         = host_rdata[PRED_W-1:0];
   assign k         = k_ff;

   always_comb begin
      if (req_row == req_col) begin
         host_wdata = {{DIST_BITS{1'b0}}, PRED_SELF};
      end else if (req_absent) begin
         host_wdata = {inf, PRED_NONE};
      end else begin
         host_wdata = {len_d, PRED_W'(req_row)};
      end
   end

   apsp_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_path (
      .clock (clock),
      .we    (buf_we),
      .waddr (buf_waddr),
      .wdata (buf_wdata),
      .re    (buf_re),
      .raddr (idx_ff),
      .rdata (buf_rdata)
   );

   always_comb begin
      state_in    = state_ff;
      k_in        = k_ff;
      s_in        = s_ff;
      r_in        = r_ff;
      c_in        = c_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      idx_in      = idx_ff;
      d_in        = d_ff;
      first_in    = first_ff;
      cell_ctrl   = '0;
      host_sel    = r_ff;
      addr        = cur_ff;
      buf_we      = 1'b0;
      buf_waddr   = cnt_ff;
      buf_wdata   = p[NODE_W-1:0];
      buf_re      = 1'b0;
      rsp_load    = 1'b0;
      rsp_node_in = c_ff;
      rsp_dist_in = d_ff;
      rsp_unr_in  = 1'b0;
      rsp_last_in = 1'b1;
      case (state_ff)
         S_IDLE: begin
            host_sel = req_row;
            addr     = req_col;
            if (accept) begin
               r_in   = req_row;
               c_in   = req_col;
               cur_in = req_col;
               if (req_func == FUNC_LOAD) begin
                  cell_ctrl.host_we = in_range;
                  if (req_last_load) begin
                     k_in     = '0;
                     s_in     = '0;
                     state_in = S_RELAX;
                  end
               end else begin
                  buf_we    = 1'b1;
                  buf_waddr = '0;
                  buf_wdata = req_col;
                  cnt_in    = NODE_W'(1);
                  first_in  = 1'b1;
                  state_in  = in_range ? S_QRD : S_ERR;
               end
            end
         end
         S_RELAX: begin
            cell_ctrl.col_re    = (s_ff == '0);
            cell_ctrl.col_latch = (s_ff == S_W'(1));
            cell_ctrl.inj_en    = (s_ff != '0) && (s_ff <= S_W'(n));
            addr = (s_ff == '0) ? k_ff : NODE_W'(s_ff - S_W'(1));
            s_in = s_ff + S_W'(1);
            if (s_ff == S_W'(n) + S_W'(MAX_NODES + 4)) begin
               s_in = '0;
               if (CNT_W'(k_ff) == n - CNT_W'(1)) begin
                  state_in = S_IDLE;
               end else begin
                  k_in = k_ff + NODE_W'(1);
               end
            end
         end
         S_QRD: begin
            cell_ctrl.host_re = 1'b1;
            state_in = S_QCHK;
         end
         S_QCHK: begin
            first_in = 1'b0;
            if (first_ff) begin
               d_in = host_rdata[ENT_W-1:PRED_W];
            end
            if (first_ff && (r_ff == c_ff)) begin
               state_in = S_ONE;
            end else if (p >= PRED_W'(n)) begin
               state_in = S_ERR;
            end else if (p == PRED_W'(r_ff)) begin
               idx_in   = cnt_ff - NODE_W'(1);
               state_in = S_ORD;
            end else if (CNT_W'(cnt_ff) >= n - CNT_W'(1)) begin
               state_in = S_ERR;
            end else begin
               buf_we   = 1'b1;
               cnt_in   = cnt_ff + NODE_W'(1);
               cur_in   = p[NODE_W-1:0];
               state_in = S_QRD;
            end
         end
         S_ORD: begin
            buf_re   = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_node_in = buf_rdata;
               rsp_last_in = (idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff - NODE_W'(1);
                  state_in = S_ORD;
               end
            end
         end
         S_ONE: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_ERR: begin
            if (slot_free) begin
               rsp_load    = 1'b1;
               rsp_dist_in = '0;
               rsp_unr_in  = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_v_in = rsp_load || (rsp_v_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         node_count_ff <= NODE_COUNT_RST;
         max_len_ff    <= MAX_LEN_RST;
         rsp_v_ff      <= 1'b0;
         k_ff          <= '0;
         s_ff          <= '0;
      end else begin
         state_ff <= state_in;
         rsp_v_ff <= rsp_v_in;
         k_ff     <= k_in;
         s_ff     <= s_in;
         if (csr_we) begin
            case (csr_index)
               CSR_NODE_COUNT: node_count_ff <= csr_wdata[4:0];
               CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
               default:        node_count_ff <= node_count_ff;
            endcase
         end
      end
      r_ff     <= r_in;
      c_ff     <= c_in;
      cur_ff   <= cur_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      d_ff     <= d_in;
      first_ff <= first_in;
      if (rsp_load) begin
         rsp_node_ff <= rsp_node_in;
         rsp_dist_ff <= rsp_dist_in;
         rsp_unr_ff  <= rsp_unr_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_node        = rsp_node_ff;
   assign rsp_distance    = rsp_dist_ff;
   assign rsp_unreachable = rsp_unr_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_check_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_QCHK) |-> $past(state_ff) == S_QRD)
      else $error("path check without a preceding read");
   a_idx_in_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT) |-> idx_ff < cnt_ff)
      else $error("path index beyond stored nodes");
   a_relax_start: assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == S_RELAX) |-> (k_ff == '0) && (s_ff == '0))
      else $error("relaxation did not start at the first pivot");
   a_no_load_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> slot_free)
      else $error("result register overwritten");
`endif

endmodule

// ===== tb/all_pairs_shortest_path_tb.sv =====
// self-checking testbench for the all-pairs shortest path block: matrix loads, relaxation,
// path queries under several csr settings and handshake idling patterns
// depends on apsp_pkg and the all_pairs_shortest_path rtl
`timescale 1ns / 100ps

typedef struct {
   logic [3:0]  node;
   logic [11:0] distance;
   logic        unreachable;
   logic        last;
} path_step_type;

class path_scoreboard_type;
   logic [11:0] dist_cells [256];
   logic [4:0]  pred_cells [256];
   int unsigned node_count_reg;
   int unsigned max_len_reg;
   path_step_type path_steps [$];
   int          errors;
   int          matched;

   function new();
      node_count_reg = 16;
      max_len_reg    = 255;
      errors         = 0;
      matched        = 0;
      foreach (dist_cells[i]) begin
         dist_cells[i] = '0;
         pred_cells[i] = '0;
      end
   endfunction

   function int unsigned nodes_used();
      if (node_count_reg < 2) return 2;
      if (node_count_reg > 16) return 16;
      return node_count_reg;
   endfunction

   function void write_csr(logic [apsp_pkg::CSR_IDX_W-1:0] idx, logic [7:0] val);
      if (idx == apsp_pkg::CSR_NODE_COUNT) node_count_reg = int'(val[4:0]);
      else if (idx == apsp_pkg::CSR_MAX_LEN) max_len_reg = int'(val);
   endfunction

   function void push_step(logic [3:0] nd, logic [11:0] d, logic unr, logic lst);
      path_step_type s;
      s.node = nd;
      s.distance = d;
      s.unreachable = unr;
      s.last = lst;
      path_steps.insert(path_steps.size(), s);
   endfunction

   function void relax_all(int unsigned n);
      int unsigned sum;
      for (int k = 0; k < n; k++)
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               sum = dist_cells[i*16+k] + dist_cells[k*16+j];
               if (sum > 4095) sum = 4095;
               if (dist_cells[i*16+j] > sum) begin
                  dist_cells[i*16+j] = sum[11:0];
                  pred_cells[i*16+j] = pred_cells[k*16+j];
               end
            end
   endfunction

   function void note_request(logic func, logic [3:0] row, logic [3:0] col, logic [7:0] len,
                              logic absent, logic last_load);
      int unsigned n;
      int unsigned inf;
      int unsigned cnt;
      int unsigned cur;
      int unsigned p;
      logic [3:0]  walk [16];
      logic [11:0] d;
      n = nodes_used();
      if (func == apsp_pkg::FUNC_LOAD) begin
         if (row < n && col < n) begin
            if (row == col) begin
               dist_cells[row*16+col] = '0;
               pred_cells[row*16+col] = 5'd17;
            end else if (absent) begin
               inf = n * max_len_reg + 1;
               dist_cells[row*16+col] = (inf > 4095) ? 12'd4095 : inf[11:0];
               pred_cells[row*16+col] = 5'd16;
            end else begin
               dist_cells[row*16+col] = {4'd0, len};
               pred_cells[row*16+col] = {1'b0, row};
            end
         end
         if (last_load) relax_all(n);
         return;
      end
      if (row >= n || col >= n) begin
         push_step(col, '0, 1'b1, 1'b1);
         return;
      end
      d = dist_cells[row*16+col];
      if (row == col) begin
         push_step(col, d, 1'b0, 1'b1);
         return;
      end
      cnt = 0;
      walk[cnt++] = col;
      cur = col;
      forever begin
         p = pred_cells[row*16+cur];
         if (p >= n) begin
            push_step(col, '0, 1'b1, 1'b1);
            return;
         end
         if (p == row) break;
         if (cnt >= n - 1) begin
            push_step(col, '0, 1'b1, 1'b1);
            return;
         end
         walk[cnt++] = p[3:0];
         cur = p;
      end
      for (int k = 0; k < cnt; k++)
         push_step(walk[cnt-1-k], d, 1'b0, k == cnt - 1);
   endfunction

   task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   task check_result(logic [3:0] nd, logic [11:0] d, logic unr, logic lst);
      path_step_type s;
      if (path_steps.size() == 0) begin
         report($sformatf("unexpected result node %0d dist %0d", nd, d));
         return;
      end
      s = path_steps.pop_front();
      matched++;
      if (nd !== s.node) report($sformatf("node %0d, want %0d", nd, s.node));
      if (d !== s.distance) report($sformatf("distance %0d, want %0d", d, s.distance));
      if (unr !== s.unreachable) report($sformatf("unreachable %b, want %b", unr, s.unreachable));
      if (lst !== s.last) report($sformatf("last %b, want %b", lst, s.last));
   endtask
endclass

module all_pairs_shortest_path_tb;
   import apsp_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;   // row, col, road_length, road_absent
   logic        req_tuser;   // func
   logic        req_tlast;   // last_load
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // node, distance
   logic        rsp_tuser;   // unreachable
   logic        rsp_tlast;   // last
   logic        csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   path_scoreboard_type sb;
   int  snd_pct;
   int  rcv_pct;
   int  hold_req;
   int  loads_sent;
   int  queries_sent;

   all_pairs_shortest_path u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // result side: random stalls plus one long hold-off
   initial begin
      int hold_done;
      hold_done = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_done) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_done = hold_req;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rcv_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata[3:0], rsp_tdata[15:4], rsp_tuser, rsp_tlast);
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_csr(idx, val);
      @(posedge clock);
   endtask

   task automatic send(logic func, logic [3:0] row, logic [3:0] col, logic [7:0] len,
                       logic absent, logic last_load);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tlast  <= last_load;
      req_tdata  <= {7'd0, absent, len, col, row};
      do @(posedge clock); while (!req_tready);
      sb.note_request(func, row, col, len, absent, last_load);
      if (func == FUNC_LOAD) loads_sent++;
      else queries_sent++;
      if ($urandom_range(99) < snd_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < snd_pct);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.path_steps.size() != 0) @(posedge clock);
      repeat (1500) @(posedge clock);
   endtask

   task automatic load_matrix(int absent_pct);
      int unsigned n;
      n = sb.nodes_used();
      for (int r = 0; r < n; r++)
         for (int c = 0; c < n; c++)
            send(FUNC_LOAD, 4'(r), 4'(c), 8'($urandom_range(255)),
                 $urandom_range(99) < absent_pct, (r == n - 1) && (c == n - 1));
   endtask

   task automatic random_mix(int count);
      int unsigned n;
      logic [3:0] r;
      logic [3:0] c;
      n = sb.nodes_used();
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 85) begin
            r = 4'($urandom_range(n - 1));
            c = 4'($urandom_range(n - 1));
         end else begin
            r = 4'($urandom_range(15));
            c = 4'($urandom_range(15));
         end
         if ($urandom_range(99) < 75)
            send(FUNC_QUERY, r, c, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 1'($urandom_range(1)));
         else
            send(FUNC_LOAD, r, c, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 $urandom_range(99) < 30);
      end
   endtask

   task automatic run_phase(logic [7:0] ncfg, logic [7:0] maxlen, int sp, int rp,
                            int absent_pct, int count, bit pressure);
      write_csr(CSR_NODE_COUNT, ncfg);
      write_csr(CSR_MAX_LEN, maxlen);
      snd_pct = sp;
      rcv_pct = rp;
      load_matrix(absent_pct);
      if (pressure) hold_req++;
      random_mix(count);
      drain();
   endtask

   initial begin
      sb = new();
      snd_pct = 0;
      rcv_pct = 0;
      hold_req = 0;
      loads_sent = 0;
      queries_sent = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= FUNC_LOAD;
      req_tlast  <= 1'b0;
      csr_we     <= 1'b0;
      csr_index  <= CSR_NODE_COUNT;
      csr_wdata  <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // two nodes from a clamped count, unit road length
      write_csr(CSR_NODE_COUNT, 8'd0);
      write_csr(CSR_MAX_LEN, 8'd1);
      send(FUNC_LOAD, 4'd0, 4'd0, 8'hff, 1'b1, 1'b0);
      send(FUNC_LOAD, 4'd0, 4'd1, 8'h00, 1'b1, 1'b0);
      send(FUNC_LOAD, 4'd1, 4'd0, 8'h00, 1'b0, 1'b0);
      send(FUNC_LOAD, 4'd15, 4'd3, 8'hff, 1'b0, 1'b0);
      send(FUNC_LOAD, 4'd1, 4'd1, 8'h5a, 1'b0, 1'b1);
      send(FUNC_QUERY, 4'd0, 4'd1, 8'h00, 1'b0, 1'b0);
      send(FUNC_QUERY, 4'd1, 4'd0, 8'h00, 1'b0, 1'b0);
      send(FUNC_QUERY, 4'd0, 4'd0, 8'hff, 1'b1, 1'b1);
      send(FUNC_QUERY, 4'd1, 4'd1, 8'h00, 1'b0, 1'b0);
      send(FUNC_QUERY, 4'd15, 4'd0, 8'h00, 1'b0, 1'b0);
      send(FUNC_QUERY, 4'd0, 4'd15, 8'h00, 1'b0, 1'b0);
      send(FUNC_LOAD, 4'd0, 4'd1, 8'hff, 1'b0, 1'b1);
      send(FUNC_QUERY, 4'd0, 4'd1, 8'h00, 1'b0, 1'b0);
      send(FUNC_LOAD, 4'd14, 4'd9, 8'h00, 1'b1, 1'b1);
      send(FUNC_QUERY, 4'd1, 4'd0, 8'h00, 1'b0, 1'b0);
      drain();

      run_phase(8'd3, 8'd255, 0, 0, 40, 8, 1'b0);
      run_phase(8'd5, 8'($urandom_range(1, 255)), 65, 0, 60, 10, 1'b0);
      run_phase(8'd6, 8'd255, 0, 65, 75, 10, 1'b1);
      run_phase(8'd4, 8'd1, 32, 32, 50, 10, 1'b0);
      run_phase(8'd1, 8'd128, 32, 32, 30, 6, 1'b0);

      $display("covered %0d loads and %0d queries, %0d path results checked",
               loads_sent, queries_sent, sb.matched);
      $display("node counts 0..6 with low counts clamped, road limits 1..255, idle and stall patterns");
      if (sb.errors == 0 && sb.path_steps.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
